[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the relay mode watchdog.
// Depends on nothing; each macro clocks on clock and is gated by reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

[rtl/hrmw_pkg.sv]
// Shared types, codes and widths for the relay mode watchdog.
// Used by hrmw_pass and hvac_relay_mode_watchdog_top; depends on nothing.
package hrmw_pkg;

   localparam int RELAY_COUNT = 4;
   localparam int MODE_W      = 3;
   localparam int ACTION_W    = 2;
   localparam int WDOG_W      = 24;
   localparam int FAN_CFG_W   = 20;
   localparam int FAN_W       = FAN_CFG_W + 1;
   localparam int CSR_INDEX_W = 1;

   localparam logic [WDOG_W-1:0]    WDOG_RESET = 24'd900000;
   localparam logic [FAN_CFG_W-1:0] FAN_RESET  = 20'd5000;

   // relays 0, 2 and 3 drop on a trip; relay 1 is the fan
   localparam logic [RELAY_COUNT-1:0] DROP_BITS = 4'b1101;
   localparam logic [RELAY_COUNT-1:0] FAN_BIT   = 4'b0010;
   localparam logic [RELAY_COUNT-1:0] PAT_COOL  = 4'b0001;
   localparam logic [RELAY_COUNT-1:0] PAT_HEAT1 = 4'b0110;
   localparam logic [RELAY_COUNT-1:0] PAT_HEAT2 = 4'b1010;
   localparam logic [RELAY_COUNT-1:0] PAT_HEAT3 = 4'b1110;

   localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MODE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAFE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COOL  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HEAT1 = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HEAT2 = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HEAT3 = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_WDOG_TICKS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAN_TICKS  = 1'd1;

   typedef struct packed {
      logic [MODE_W-1:0]      mode;
      logic                   applied;
      logic                   tripped;
      logic [RELAY_COUNT-1:0] relay;
      logic [WDOG_W-1:0]      wd_left;
      logic [FAN_W-1:0]       fan_left;
   } ctl_state_type;

   function automatic logic is_heating(input logic [MODE_W-1:0] m);
      return (m == MODE_HEAT1) || (m == MODE_HEAT2) || (m == MODE_HEAT3);
   endfunction

endpackage

[rtl/hvac_relay_mode_watchdog_top.sv]
// Top level of the relay mode watchdog: stream ports, config registers, result register.
// Depends on hrmw_pkg, hrmw_pass and assert_macros.svh.
//
// One word is taken per clock cycle while the rsp side is not stalled, and its result
// appears on the rsp side in the cycle after acceptance from a single result register;
// req_tready is high whenever that register is empty or being taken in the same cycle,
// so words flow back to back. The control state and the watchdog and fan counters update
// at the edge where a word is accepted. Configuration writes are always taken
// (csr_ready is tied high) and should be made while no word is in flight.
`include "assert_macros.svh"

module hvac_relay_mode_watchdog_top (
   input  logic                                clock,
   input  logic                                reset,
   // req side
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [2:0] mode_code
   input  logic [hrmw_pkg::ACTION_W-1:0]       req_tuser,  // [1:0] action
   // rsp side
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // [3:0] relay_states,
                                                            // [6:4] current_mode,
                                                            // [7] watchdog_tripped,
                                                            // [8] command_rejected
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hrmw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hrmw_pkg::WDOG_W-1:0]         csr_data
);

   logic [hrmw_pkg::WDOG_W-1:0]    wdog_ticks_ff;
   logic [hrmw_pkg::FAN_CFG_W-1:0] fan_ticks_ff;
   hrmw_pkg::ctl_state_type        state_ff;
   hrmw_pkg::ctl_state_type        state_in;
   logic                           rejected;
   logic                           rsp_valid_ff;
   logic [15:0]                    rsp_data_ff;
   logic                           req_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wdog_ticks_ff <= hrmw_pkg::WDOG_RESET;
         fan_ticks_ff  <= hrmw_pkg::FAN_RESET;
      end else if (csr_valid) begin
         if (csr_index == hrmw_pkg::CSR_WDOG_TICKS) wdog_ticks_ff <= csr_data;
         if (csr_index == hrmw_pkg::CSR_FAN_TICKS)
            fan_ticks_ff <= csr_data[hrmw_pkg::FAN_CFG_W-1:0];
      end
   end

   hrmw_pass u_pass (
      .cur        (state_ff),
      .action     (req_tuser),
      .mode_code  (req_tdata[hrmw_pkg::MODE_W-1:0]),
      .wdog_ticks (wdog_ticks_ff),
      .fan_ticks  (fan_ticks_ff),
      .nxt        (state_in),
      .rejected   (rejected)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: load on accept only
   always_ff @(posedge clock) begin
      if (req_accept)
         rsp_data_ff <= {7'd0, rejected, state_in.tripped, state_in.mode, state_in.relay};
   end

   `ASSERT_CLK(a_trip_relays_low,
      !state_ff.tripped || ((state_ff.relay & hrmw_pkg::DROP_BITS) == '0),
      "tripped watchdog with a dropped relay still on")
   `ASSERT_CLK(a_trip_expired,
      !state_ff.tripped || (state_ff.wd_left == '0),
      "tripped flag set while watchdog still running")
   `ASSERT_NEXT(a_rsp_drains,
      rsp_valid_ff && rsp_tready && !req_accept,
      !rsp_valid_ff,
      "result word not released after being taken")

endmodule

[rtl/hrmw_pass.sv]
// One control pass of the relay mode watchdog: next state from state and word.
// Depends on hrmw_pkg.
module hrmw_pass (
   input  hrmw_pkg::ctl_state_type                 cur,
   input  logic [hrmw_pkg::ACTION_W-1:0]           action,
   input  logic [hrmw_pkg::MODE_W-1:0]             mode_code,
   input  logic [hrmw_pkg::WDOG_W-1:0]             wdog_ticks,
   input  logic [hrmw_pkg::FAN_CFG_W-1:0]          fan_ticks,
   output hrmw_pkg::ctl_state_type                 nxt,
   output logic                                    rejected
);

   always_comb begin
      hrmw_pkg::ctl_state_type s;
      logic                    code_ok;
      s        = cur;
      rejected = 1'b0;
      code_ok  = (mode_code <= hrmw_pkg::MODE_HEAT3);

      // apply the action
      unique case (action)
         hrmw_pkg::ACT_TICK: begin
            if (s.wd_left != '0) s.wd_left = s.wd_left - 1'b1;
            if (s.fan_left != '0) s.fan_left = s.fan_left - 1'b1;
         end
         hrmw_pkg::ACT_SAFE: begin
            s.wd_left = '0;
            s.tripped = 1'b0;
            s.relay   = '0;
         end
         hrmw_pkg::ACT_MODE: begin
            if (code_ok) begin
               if (mode_code <= hrmw_pkg::MODE_COOL && hrmw_pkg::is_heating(cur.mode))
                  s.fan_left = {1'b0, fan_ticks} + 1'b1;
               s.applied = (cur.mode == mode_code);
               s.mode    = mode_code;
               s.wd_left = wdog_ticks;
            end else begin
               rejected = 1'b1;
            end
         end
         default: ;
      endcase

      // watchdog pass: drive a new pattern while running, drop once on expiry
      if (s.wd_left != '0) begin
         s.tripped = 1'b0;
         if (!s.applied) begin
            case (s.mode)
               hrmw_pkg::MODE_OFF:   s.relay = s.relay & hrmw_pkg::FAN_BIT;
               hrmw_pkg::MODE_COOL:  s.relay = (s.relay & hrmw_pkg::FAN_BIT) | hrmw_pkg::PAT_COOL;
               hrmw_pkg::MODE_HEAT1: s.relay = hrmw_pkg::PAT_HEAT1;
               hrmw_pkg::MODE_HEAT2: s.relay = hrmw_pkg::PAT_HEAT2;
               hrmw_pkg::MODE_HEAT3: s.relay = hrmw_pkg::PAT_HEAT3;
               default: ;
            endcase
            s.applied = 1'b1;
         end
      end else if (!s.tripped) begin
         s.relay   = s.relay & ~hrmw_pkg::DROP_BITS;
         s.tripped = 1'b1;
      end

      // fan cooloff
      if (!hrmw_pkg::is_heating(s.mode) && s.fan_left == '0)
         s.relay = s.relay & ~hrmw_pkg::FAN_BIT;

      nxt = s;
   end

endmodule

[tb/sv/hvac_relay_mode_watchdog_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for hvac_relay_mode_watchdog_top: a queue-fed stream driver with a built-in
// model of the relay pass, a result monitor, and config phases. Needs hrmw_pkg and the RTL.
module hvac_relay_mode_watchdog_top_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 6;

   typedef logic [hrmw_pkg::MODE_W-1:0] mode_type;

   typedef struct packed {
      logic [hrmw_pkg::ACTION_W-1:0] action;
      logic [hrmw_pkg::MODE_W-1:0]   code;
   } ctl_word_type;

   typedef struct packed {
      logic                             rejected;
      logic                             tripped;
      logic [hrmw_pkg::MODE_W-1:0]      mode;
      logic [hrmw_pkg::RELAY_COUNT-1:0] relays;
   } relay_report_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata  = '0;  // [2:0] mode_code
   logic [hrmw_pkg::ACTION_W-1:0]    req_tuser  = '0;  // [1:0] action
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // [3:0] relays, [6:4] mode, [7] tripped, [8] rejected
   logic [15:0]                      rsp_tdata;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [hrmw_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [hrmw_pkg::WDOG_W-1:0]      csr_data   = '0;

   hvac_relay_mode_watchdog_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   ctl_word_type     pending_words[$];
   relay_report_type expected_reports[$];
   int               error_count = 0;
   int               stall_pct   = 34;
   int               idle_cycles = 0;

   // shadow of the block's limits and control state
   logic [hrmw_pkg::WDOG_W-1:0]      wdog_limit = hrmw_pkg::WDOG_RESET;
   logic [hrmw_pkg::FAN_CFG_W-1:0]   fan_limit  = hrmw_pkg::FAN_RESET;
   logic [hrmw_pkg::MODE_W-1:0]      mode_now   = hrmw_pkg::MODE_OFF;
   logic                             pattern_on = 1'b0;
   logic                             trip_now   = 1'b0;
   logic [hrmw_pkg::RELAY_COUNT-1:0] relays_now = '0;
   logic [hrmw_pkg::WDOG_W-1:0]      wdog_count = '0;
   logic [hrmw_pkg::FAN_W-1:0]       fan_count  = '0;

   function automatic logic heating_mode(input logic [hrmw_pkg::MODE_W-1:0] m);
      return (m >= hrmw_pkg::MODE_HEAT1) && (m <= hrmw_pkg::MODE_HEAT3);
   endfunction

   function automatic relay_report_type run_control_pass(input ctl_word_type w);
      relay_report_type rep;
      rep.rejected = 1'b0;
      case (w.action)
         hrmw_pkg::ACT_TICK: begin
            if (wdog_count != 0) wdog_count = wdog_count - 1'b1;
            if (fan_count != 0) fan_count = fan_count - 1'b1;
         end
         hrmw_pkg::ACT_SAFE: begin
            wdog_count = '0;
            trip_now   = 1'b0;
            relays_now = '0;
         end
         hrmw_pkg::ACT_MODE: begin
            if (w.code <= hrmw_pkg::MODE_HEAT3) begin
               // leaving heating starts the fan cooloff
               if (w.code <= hrmw_pkg::MODE_COOL && heating_mode(mode_now))
                  fan_count = {1'b0, fan_limit} + 1'b1;
               pattern_on = (mode_now == w.code);
               mode_now   = w.code;
               wdog_count = wdog_limit;
            end else begin
               rep.rejected = 1'b1;
            end
         end
         default: ;
      endcase
      if (wdog_count != 0) begin
         trip_now = 1'b0;
         if (!pattern_on) begin
            case (mode_now)
               hrmw_pkg::MODE_OFF:
                  relays_now = relays_now & ~hrmw_pkg::DROP_BITS;
               hrmw_pkg::MODE_COOL:
                  relays_now = (relays_now & ~hrmw_pkg::DROP_BITS) | hrmw_pkg::PAT_COOL;
               hrmw_pkg::MODE_HEAT1: relays_now = hrmw_pkg::PAT_HEAT1;
               hrmw_pkg::MODE_HEAT2: relays_now = hrmw_pkg::PAT_HEAT2;
               hrmw_pkg::MODE_HEAT3: relays_now = hrmw_pkg::PAT_HEAT3;
               default: ;
            endcase
            pattern_on = 1'b1;
         end
      end else if (!trip_now) begin
         relays_now = relays_now & ~hrmw_pkg::DROP_BITS;
         trip_now   = 1'b1;
      end
      if (!heating_mode(mode_now) && fan_count == 0)
         relays_now = relays_now & ~hrmw_pkg::FAN_BIT;
      rep.relays  = relays_now;
      rep.mode    = mode_now;
      rep.tripped = trip_now;
      return rep;
   endfunction

   task automatic log_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // driver: present the next word once the current one is taken
   always @(posedge clock) begin : drive_proc
      ctl_word_type     nxt;
      relay_report_type pred;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pred = run_control_pass({req_tuser, req_tdata[hrmw_pkg::MODE_W-1:0]});
            expected_reports.insert(expected_reports.size(), pred);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= stall_pct) begin
               nxt = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, nxt.code};
               req_tuser  <= nxt.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: take results, compare against the oldest prediction, track limit writes
   always @(posedge clock) begin : monitor_proc
      relay_report_type want;
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            hrmw_pkg::CSR_WDOG_TICKS: wdog_limit = csr_data;
            hrmw_pkg::CSR_FAN_TICKS:  fan_limit  = csr_data[hrmw_pkg::FAN_CFG_W-1:0];
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            log_mismatch("result with nothing pending", rsp_tdata, '0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tdata[3:0] !== want.relays)
               log_mismatch("relay_states", {12'd0, rsp_tdata[3:0]}, {12'd0, want.relays});
            if (rsp_tdata[6:4] !== want.mode)
               log_mismatch("current_mode", {13'd0, rsp_tdata[6:4]}, {13'd0, want.mode});
            if (rsp_tdata[7] !== want.tripped)
               log_mismatch("watchdog_tripped", {15'd0, rsp_tdata[7]}, {15'd0, want.tripped});
            if (rsp_tdata[8] !== want.rejected)
               log_mismatch("command_rejected", {15'd0, rsp_tdata[8]}, {15'd0, want.rejected});
         end
      end
   end

   // hang detector: count cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("hvac_relay_mode_watchdog_top_tb: errors");
         $finish;
      end
   end

   task automatic queue_word(input logic [hrmw_pkg::ACTION_W-1:0] act,
                             input logic [hrmw_pkg::MODE_W-1:0] code);
      ctl_word_type w;
      w.action = act;
      w.code   = code;
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic queue_random_words(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 50)
            queue_word(hrmw_pkg::ACT_TICK, mode_type'($urandom_range(7)));
         else if (pick < 82)
            queue_word(hrmw_pkg::ACT_MODE,
                       ($urandom_range(99) < 85) ? mode_type'($urandom_range(4))
                                                 : mode_type'($urandom_range(7, 5)));
         else if (pick < 91)
            queue_word(hrmw_pkg::ACT_SAFE, mode_type'($urandom_range(7)));
         else
            queue_word(hrmw_pkg::ACT_NONE, mode_type'($urandom_range(7)));
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_reports.size() != 0);
   endtask

   task automatic write_limits(input logic [hrmw_pkg::WDOG_W-1:0] wd,
                               input logic [hrmw_pkg::FAN_CFG_W-1:0] fan);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= hrmw_pkg::CSR_WDOG_TICKS;
      csr_data  <= wd;
      do @(posedge clock); while (!csr_ready);
      csr_index <= hrmw_pkg::CSR_FAN_TICKS;
      csr_data  <= {{(hrmw_pkg::WDOG_W - hrmw_pkg::FAN_CFG_W){1'b0}}, fan};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   logic [hrmw_pkg::WDOG_W-1:0]    phase_wdog[PHASES] =
      '{24'd3, 24'd1, 24'd0, 24'hFFFFFF, 24'd12, 24'd2};
   logic [hrmw_pkg::FAN_CFG_W-1:0] phase_fan[PHASES]  =
      '{20'd0, 20'd2, 20'd1, 20'hFFFFF, 20'd6, 20'd1};
   int                             phase_len[PHASES]  = '{175, 170, 60, 140, 250, 240};

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: every action, every code, repeats, trips and safe resets
      queue_word(hrmw_pkg::ACT_TICK, hrmw_pkg::MODE_OFF);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_HEAT3);
      queue_word(hrmw_pkg::ACT_TICK, hrmw_pkg::MODE_OFF);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_HEAT3);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_COOL);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_OFF);
      queue_word(hrmw_pkg::ACT_MODE, 3'd5);
      queue_word(hrmw_pkg::ACT_MODE, 3'd6);
      queue_word(hrmw_pkg::ACT_MODE, 3'd7);
      queue_word(hrmw_pkg::ACT_NONE, 3'd7);
      queue_word(hrmw_pkg::ACT_SAFE, hrmw_pkg::MODE_OFF);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_HEAT1);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_HEAT2);
      queue_word(hrmw_pkg::ACT_TICK, 3'd7);
      queue_word(hrmw_pkg::ACT_SAFE, 3'd5);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_HEAT2);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_COOL);
      queue_word(hrmw_pkg::ACT_NONE, hrmw_pkg::MODE_OFF);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_HEAT3);
      queue_word(hrmw_pkg::ACT_MODE, hrmw_pkg::MODE_OFF);
      queue_word(hrmw_pkg::ACT_TICK, hrmw_pkg::MODE_HEAT3);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_limits(phase_wdog[p], phase_fan[p]);
         // run one phase; both sides stream flat out in phase 4 only and stall at random otherwise
         stall_pct = (p == 4) ? 0 : 34;
         queue_random_words(phase_len[p]);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("hvac_relay_mode_watchdog_top_tb: clean");
      else
         $display("hvac_relay_mode_watchdog_top_tb: errors");
      $finish;
   end

endmodule
